>>> sv/fbpa_pkg.sv
// Shared types, constants and register map for the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BUFFERS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int DATA_W  = 32;
    localparam int CFG_AW  = 4;
    localparam int POOL_W  = 5;
    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [POOL_W-1:0] POOL_COUNT_RST   = 5'd16;
    localparam logic [DATA_W-1:0] STRIDE_RST       = 32'd4096;
    localparam logic [DATA_W-1:0] BASE_ADDRESS_RST = 32'd0;

    localparam logic FUNC_GET    = 1'b0;
    localparam logic FUNC_RETURN = 1'b1;

    typedef enum logic [1:0] {
        REG_POOL_COUNT   = 2'd0,
        REG_STRIDE       = 2'd1,
        REG_BASE_ADDRESS = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [POOL_W-1:0] pool_count;
        logic [DATA_W-1:0] stride;
        logic [DATA_W-1:0] base_address;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic early_fail;
        logic hit;
        logic last;
    } t_dp_sts;

endpackage

>>> sv/fbpa_regs.sv
// APB configuration registers: pool count, buffer size and base address.
module fbpa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::CFG_AW-1:0]   paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output fbpa_pkg::t_cfg                o_cfg
);
    import fbpa_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_count   <= POOL_COUNT_RST;
            r_cfg.stride       <= STRIDE_RST;
            r_cfg.base_address <= BASE_ADDRESS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POOL_COUNT:   r_cfg.pool_count   <= pwdata[POOL_W-1:0];
                REG_STRIDE:       r_cfg.stride       <= pwdata;
                REG_BASE_ADDRESS: r_cfg.base_address <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POOL_COUNT:   prdata = DATA_W'(r_cfg.pool_count);
            REG_STRIDE:       prdata = r_cfg.stride;
            REG_BASE_ADDRESS: prdata = r_cfg.base_address;
            default:          prdata = '0;
        endcase
    end

endmodule

>>> sv/fbpa_dp.sv
// Datapath: in-use flags, busy count, address accumulator and scan index.
module fbpa_dp #(
    parameter int MAX_BUFFERS = fbpa_pkg::MAX_BUFFERS_DEF,
    parameter int ADDR_BITS   = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbpa_pkg::t_cfg                i_cfg,
    input  logic                          i_func,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_address,
    input  fbpa_pkg::t_dp_cmd             i_cmd,
    output fbpa_pkg::t_dp_sts             o_sts,
    output logic [fbpa_pkg::DATA_W-1:0]   o_granted_address,
    output logic                          o_success,
    output logic [fbpa_pkg::COUNT_W-1:0]  o_busy_total
);
    import fbpa_pkg::*;

    localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int EN_W  = (CNT_W > POOL_W) ? CNT_W : POOL_W;
    localparam int CMP_W = (ADDR_BITS > DATA_W) ? ADDR_BITS : DATA_W;
    localparam logic [EN_W-1:0] EN_MAX = EN_W'(MAX_BUFFERS);

    logic [MAX_BUFFERS-1:0] r_flags;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_func;
    logic [DATA_W-1:0]      r_addr;
    logic [IDX_W-1:0]       r_idx;
    logic [ADDR_BITS-1:0]   r_acc;
    logic [DATA_W-1:0]      r_granted;
    logic                   r_success;

    logic [EN_W-1:0] pool_ext;
    logic [EN_W-1:0] n_enabled;
    logic            flag_cur;
    logic            addr_match;

    assign pool_ext   = EN_W'(i_cfg.pool_count);
    assign n_enabled  = (pool_ext > EN_MAX) ? EN_MAX : pool_ext;
    assign flag_cur   = r_flags[r_idx];
    assign addr_match = CMP_W'(r_acc) == CMP_W'(r_addr);

    assign o_sts.early_fail = (n_enabled == '0) || ((r_func == FUNC_RETURN) && (r_addr == '0));
    assign o_sts.hit        = (r_func == FUNC_GET) ? !flag_cur : addr_match;
    assign o_sts.last       = EN_W'(r_idx) == (n_enabled - EN_W'(1));

    assign o_granted_address = r_granted;
    assign o_success         = r_success;
    assign o_busy_total      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_func == FUNC_GET) begin
                r_flags[r_idx] <= 1'b1;
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end else if (flag_cur) begin
                r_flags[r_idx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_addr    <= i_buffer_address;
            r_idx     <= '0;
            r_acc     <= ADDR_BITS'(i_cfg.base_address);
            r_success <= 1'b0;
            r_granted <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            r_acc <= r_acc + ADDR_BITS'(i_cfg.stride);
        end else if (i_cmd.commit) begin
            r_success <= 1'b1;
            r_granted <= (r_func == FUNC_GET) ? DATA_W'(r_acc) : '0;
        end
    end

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_count))
        else $error("busy count moved without a commit");

    a_commit_succeeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_success)
        else $error("commit did not report success");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !r_success && (r_granted == '0))
        else $error("result not cleared on load");

endmodule

>>> sv/fbpa_ctrl.sv
// Controller: sequences the buffer scan and raises the result strobe.
module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fbpa_pkg::t_dp_sts   i_sts,
    output fbpa_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.early_fail || i_sts.hit || i_sts.last) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SCAN: begin
                if (!i_sts.early_fail) begin
                    if (i_sts.hit) begin
                        o_cmd.commit = 1'b1;
                    end else if (!i_sts.last) begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            ST_DONE: o_done = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_state == ST_IDLE))
        else $error("result strobe held past one cycle");

endmodule

>>> sv/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: registers, controller and datapath.
//
//   channel   signals                                   beat taken when
//   config    psel penable pwrite paddr pwdata prdata   psel & penable & pready
//   command   start i_func i_buffer_address busy        start & !busy
//   result    o_done o_granted_address o_success        o_done (one cycle)
//             o_busy_total
//
// A command scans the in-use flags one buffer per cycle, stepping the address adder,
// and stops at a hit or at the last enabled buffer.
// A return of address zero or an empty pool ends without scanning any buffer.
// busy is high from the beat after start until the result cycle ends.
// Reset is synchronous: all buffers free, count zero, registers at defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BUFFERS = fbpa_pkg::MAX_BUFFERS_DEF,
    parameter int ADDR_BITS   = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::CFG_AW-1:0]   paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    input  logic                          i_func,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_address,
    output logic                          busy,
    output logic                          o_done,
    output logic [fbpa_pkg::DATA_W-1:0]   o_granted_address,
    output logic                          o_success,
    output logic [fbpa_pkg::COUNT_W-1:0]  o_busy_total
);
    import fbpa_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    fbpa_dp #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_func            (i_func),
        .i_buffer_address  (i_buffer_address),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_granted_address (o_granted_address),
        .o_success         (o_success),
        .o_busy_total      (o_busy_total)
    );

endmodule
